// ===== design/mtk_pkg.sv =====
// ----------------------------------------------------------------------------
// mtk_pkg: shared types, codes and key tables
// Event and action codes, the result word and the multi-tap character
// tables used by the keypad entry block.
// ----------------------------------------------------------------------------
`default_nettype none

package mtk_pkg;

    // text length limit, letter case offset, key count and tap timeout reset value
    localparam logic [7:0]  MAX_LEN     = 8'd128;
    localparam logic [7:0]  CASE_SHIFT  = 8'd32;
    localparam logic [3:0]  NUM_KEYS    = 4'd12;
    localparam logic [15:0] TIMEOUT_RST = 16'd1000;

    // configuration register indexes (byte address bit 2)
    localparam logic [0:0]  REG_TAP_TIMEOUT = 1'b0;

    // input event kinds
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_KEY    = 3'd1;
    localparam logic [2:0] KIND_BACK   = 3'd2;
    localparam logic [2:0] KIND_CASE   = 3'd3;
    localparam logic [2:0] KIND_FINISH = 3'd4;

    // result actions
    localparam logic [1:0] ACT_APPEND  = 2'd0;
    localparam logic [1:0] ACT_REPLACE = 2'd1;
    localparam logic [1:0] ACT_ERASE   = 2'd2;
    localparam logic [1:0] ACT_END     = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] key_code;
    } t_item;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] char_code;
        logic [7:0] text_length;
    } t_result;

    // number of characters in a key's cycle
    function automatic logic [2:0] cycle_len(input logic [3:0] key);
        logic [2:0] n;
        unique case (key)
            4'd0, 4'd1:                      n = 3'd2;
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6:    n = 3'd4;
            4'd7, 4'd9:                      n = 3'd5;
            4'd8:                            n = 3'd4;
            default:                         n = 3'd1;
        endcase
        return n;
    endfunction

    // character at a position of a key's cycle, before case shift
    function automatic logic [7:0] cycle_char(input logic [3:0] key, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (key)
            4'd0: if (pos == 3'd0) c = "0"; else if (pos == 3'd1) c = " ";
            4'd1: if (pos == 3'd0) c = "1"; else if (pos == 3'd1) c = ";";
            4'd7: unique case (pos)
                3'd0: c = "7";
                3'd1: c = "P";
                3'd2: c = "Q";
                3'd3: c = "R";
                3'd4: c = "S";
                default: c = 8'h00;
            endcase
            4'd9: unique case (pos)
                3'd0: c = "9";
                3'd1: c = "W";
                3'd2: c = "X";
                3'd3: c = "Y";
                3'd4: c = "Z";
                default: c = 8'h00;
            endcase
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8: begin
                // three letters after the digit, letters laid out in key order
                if (pos == 3'd0) begin
                    c = 8'h30 + {4'd0, key};
                end else if (pos <= 3'd3) begin
                    priority case (key)
                        4'd2:    c = 8'h40 + {5'd0, pos};
                        4'd3:    c = 8'h43 + {5'd0, pos};
                        4'd4:    c = 8'h46 + {5'd0, pos};
                        4'd5:    c = 8'h49 + {5'd0, pos};
                        4'd6:    c = 8'h4C + {5'd0, pos};
                        default: c = 8'h53 + {5'd0, pos};
                    endcase
                end
            end
            4'd10: if (pos == 3'd0) c = "*";
            4'd11: if (pos == 3'd0) c = "#";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // character with the case flag applied to letters only
    function automatic logic [6:0] key_char(input logic [3:0] key, input logic [2:0] pos,
                                            input logic lower);
        logic [7:0] c;
        c = cycle_char(key, pos);
        if (lower && c >= "A" && c <= "Z") begin
            c = c + CASE_SHIFT;
        end
        return c[6:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/mtk_if.sv =====
// ----------------------------------------------------------------------------
// mtk_if: keypad event and edit result channels
// Valid/ready channels that carry one event word and one edit word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtk_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [3:0] key_code;

    modport source (output valid, output kind, output key_code, input ready);
    modport sink   (input valid, input kind, input key_code, output ready);
endinterface

interface mtk_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [6:0] char_code;
    logic [7:0] text_length;

    modport source (output valid, output action, output char_code, output text_length,
                    input ready);
    modport sink   (input valid, input action, input char_code, input text_length,
                    output ready);
endinterface

`default_nettype wire

// ===== design/mtk_core.sv =====
// ----------------------------------------------------------------------------
// mtk_core: multi-tap entry state and edit decision
// Holds the tap window, case flag and text length, and works out the edit
// for one event word combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module mtk_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire mtk_pkg::t_item  i_item,
    input  wire logic [15:0]     i_tap_timeout,
    output logic                 o_res_valid,
    output mtk_pkg::t_result     o_res
);
    import mtk_pkg::*;

    logic [3:0]  r_last_key,   n_last_key;
    logic [2:0]  r_tap_count,  n_tap_count;
    logic [15:0] r_idle_ticks, n_idle_ticks;
    logic        r_window,     n_window;
    logic        r_lower,      n_lower;
    logic [7:0]  r_length,     n_length;

    logic [15:0] idle_inc;
    logic [2:0]  tap_inc;
    logic        same_key;

    assign idle_inc = (r_idle_ticks != 16'hFFFF) ? r_idle_ticks + 16'd1 : r_idle_ticks;
    assign tap_inc  = (r_tap_count + 3'd1 >= cycle_len(i_item.key_code)) ? 3'd0
                    : r_tap_count + 3'd1;
    assign same_key = r_window && (i_item.key_code == r_last_key) && (r_length != 8'd0);

    // next state and edit word for the current event
    always_comb begin
        n_last_key   = r_last_key;
        n_tap_count  = r_tap_count;
        n_idle_ticks = r_idle_ticks;
        n_window     = r_window;
        n_lower      = r_lower;
        n_length     = r_length;
        o_res_valid  = 1'b0;
        o_res        = '{action: ACT_APPEND, char_code: 7'd0, text_length: r_length};
        unique case (i_item.kind)
            KIND_TICK: begin
                n_idle_ticks = idle_inc;
                if (r_window && idle_inc >= i_tap_timeout) begin
                    n_window = 1'b0;
                end
            end
            KIND_KEY: begin
                if (i_item.key_code < NUM_KEYS) begin
                    if (same_key) begin
                        n_tap_count  = tap_inc;
                        n_idle_ticks = 16'd0;
                        o_res_valid  = 1'b1;
                        o_res.action = ACT_REPLACE;
                        o_res.char_code = key_char(i_item.key_code, tap_inc, r_lower);
                    end else if (r_length < MAX_LEN) begin
                        n_tap_count  = 3'd0;
                        n_last_key   = i_item.key_code;
                        n_idle_ticks = 16'd0;
                        n_window     = 1'b1;
                        n_length     = r_length + 8'd1;
                        o_res_valid  = 1'b1;
                        o_res.action = ACT_APPEND;
                        o_res.char_code   = key_char(i_item.key_code, 3'd0, r_lower);
                        o_res.text_length = r_length + 8'd1;
                    end
                end
            end
            KIND_BACK: begin
                if (r_length != 8'd0) begin
                    n_length    = r_length - 8'd1;
                    n_window    = 1'b0;
                    n_tap_count = 3'd0;
                    o_res_valid = 1'b1;
                    o_res.action      = ACT_ERASE;
                    o_res.text_length = r_length - 8'd1;
                end
            end
            KIND_CASE: begin
                n_lower = ~r_lower;
            end
            KIND_FINISH: begin
                o_res_valid  = 1'b1;
                o_res.action = ACT_END;
                n_length     = 8'd0;
                n_tap_count  = 3'd0;
                n_idle_ticks = 16'd0;
                n_window     = 1'b0;
                n_lower      = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // entry state, updated once per processed event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_key   <= 4'd0;
            r_tap_count  <= 3'd0;
            r_idle_ticks <= 16'd0;
            r_window     <= 1'b0;
            r_lower      <= 1'b0;
            r_length     <= 8'd0;
        end else if (i_step) begin
            r_last_key   <= n_last_key;
            r_tap_count  <= n_tap_count;
            r_idle_ticks <= n_idle_ticks;
            r_window     <= n_window;
            r_lower      <= n_lower;
            r_length     <= n_length;
        end
    end

endmodule

`default_nettype wire

// ===== design/multi_tap_keypad_entry_top.sv =====
// ----------------------------------------------------------------------------
// multi_tap_keypad_entry_top: multi-tap keypad text entry
// Turns keypad events into append, replace, erase and end-of-entry edits.
//
// i_in carries one event word per handshake: a tick, a key press, a
// backspace, a case toggle or a finish. o_out carries at most one edit word
// per event; ticks, case toggles, ignored keys and dropped presses give none.
// The APB port holds tap_timeout at byte address 0 (reset 1000 ticks).
// An event is captured in an input register and decided there by the single
// decision stage; its edit word moves into the output register once that
// register is free or being taken. One event is taken per cycle while the
// receiver keeps taking edit words. When the
// receiver stalls, the edit word holds in the output register while the
// next event still waits in the input register; i_in.ready drops only while
// both are full. Reset empties both registers, clears the text and case
// state, and sets tap_timeout back to 1000; no clearing pass follows.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_tap_keypad_entry_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    mtk_in_if.sink            i_in,
    mtk_out_if.source         o_out,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import mtk_pkg::*;

    logic [15:0] r_tap_timeout;
    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_result     r_out;
    logic        advance;
    logic        res_valid;
    t_result     res;

    // register access
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TAP_TIMEOUT) ? {16'd0, r_tap_timeout} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_timeout <= TIMEOUT_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_TAP_TIMEOUT) begin
            r_tap_timeout <= pwdata[15:0];
        end
    end

    // input register moves on when the output register can take its word
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= '{kind: i_in.kind, key_code: i_in.key_code};
        end
    end

    // edit decision
    mtk_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_item        (r_in),
        .i_tap_timeout (r_tap_timeout),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.action      = r_out.action;
    assign o_out.char_code   = r_out.char_code;
    assign o_out.text_length = r_out.text_length;

    // checks
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_out_valid && !o_out.ready))
        else $error("input stalled while a register was free");

    a_append_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action == ACT_APPEND) |-> (r_out.text_length != 8'd0))
        else $error("append reported an empty text");

    a_length_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.text_length <= MAX_LEN))
        else $error("text length beyond limit");

    a_no_char_on_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.action == ACT_ERASE || r_out.action == ACT_END))
        |-> (r_out.char_code == 7'd0))
        else $error("character on erase or end of entry");

    a_word_taken_or_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled edit word changed");

endmodule

`default_nettype wire
